@@ src/nms_pkg.sv @@
// shared types, constants and control words of the box suppression block
`timescale 1ns / 1ps
`default_nettype none
package nms_pkg;

    localparam int unsigned MAX_BOXES   = 64;
    localparam int unsigned MAX_RESULTS = 64;
    localparam int unsigned IDX_W       = $clog2(MAX_BOXES);
    localparam int unsigned CNT_W       = $clog2(MAX_BOXES + 1);
    localparam int unsigned OUT_CAP     = (MAX_RESULTS < MAX_BOXES) ? MAX_RESULTS : MAX_BOXES;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_IOU_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONF_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OUT  = 2'd2;

    localparam logic [15:0] IOU_THR_RST  = 16'd16384;
    localparam logic [15:0] CONF_THR_RST = 16'd16384;
    localparam logic [6:0]  MAX_OUT_RST  = 7'd64;

    typedef struct packed {
        logic [7:0]         class_id;
        logic [15:0]        score;
        logic [14:0]        height;
        logic [14:0]        width;
        logic signed [15:0] top;
        logic signed [15:0] left;
    } box_t;

    localparam int unsigned BOX_W = $bits(box_t);

    typedef struct packed {
        logic load_en;
        logic scan_clr;
        logic scan_issue;
        logic pick;
        logic chk_issue;
        logic surv_push;
        logic em_start;
        logic em_issue;
        logic em_load;
        logic em_empty;
        logic set_clr;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic scan_busy;
        logic found;
        logic chk_done;
        logic pipe_busy;
        logic hit;
        logic em_none;
        logic em_done;
        logic out_full;
    } sts_t;

endpackage
`default_nettype wire

@@ src/nms_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module nms_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ src/nms_ctrl.sv @@
// sequencer for load, ranking, overlap check and emit phases
`timescale 1ns / 1ps
`default_nettype none
module nms_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_set_end,
    output logic             s_ready,
    input  wire nms_pkg::sts_t sts,
    output nms_pkg::cmd_t    cmd
);
    import nms_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_CHECK,
        ST_EMIT,
        ST_EMIT_LD
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready     = 1'b1;
                cmd.load_en = s_valid;
                if (s_valid && s_set_end) begin
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!sts.scan_done) begin
                    cmd.scan_issue = 1'b1;
                end else if (!sts.scan_busy) begin
                    if (sts.found) begin
                        cmd.pick   = 1'b1;
                        state_next = ST_CHECK;
                    end else begin
                        cmd.em_start = 1'b1;
                        state_next   = ST_EMIT;
                    end
                end
            end
            ST_CHECK: begin
                if (!sts.chk_done) begin
                    cmd.chk_issue = 1'b1;
                end else if (!sts.pipe_busy) begin
                    cmd.surv_push = !sts.hit;
                    cmd.scan_clr  = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_EMIT: begin
                if (sts.em_none) begin
                    if (!sts.out_full) begin
                        cmd.em_empty = 1'b1;
                        cmd.set_clr  = 1'b1;
                        state_next   = ST_LOAD;
                    end
                end else if (sts.em_done) begin
                    cmd.set_clr = 1'b1;
                    state_next  = ST_LOAD;
                end else if (!sts.out_full) begin
                    cmd.em_issue = 1'b1;
                    state_next   = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                cmd.em_load = 1'b1;
                state_next  = ST_EMIT;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

@@ src/nms_dp.sv @@
// stores, counters, overlap arithmetic and output register
`timescale 1ns / 1ps
`default_nettype none
module nms_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire nms_pkg::cmd_t                     cmd,
    output nms_pkg::sts_t                          sts,
    input  wire logic                              cfg_we,
    input  wire logic [nms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [nms_pkg::CFG_DAT_W-1:0]     cfg_wdata,
    input  wire nms_pkg::box_t                     in_box,
    output nms_pkg::box_t                          out_box,
    output logic                                   out_run_end,
    output logic                                   out_none,
    output logic                                   out_valid,
    input  wire logic                              out_ready
);
    import nms_pkg::*;

    logic [15:0] iou_thr_reg, conf_thr_reg;
    logic [6:0]  max_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iou_thr_reg  <= IOU_THR_RST;
            conf_thr_reg <= CONF_THR_RST;
            max_out_reg  <= MAX_OUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IOU_THR:  iou_thr_reg  <= cfg_wdata;
                REG_CONF_THR: conf_thr_reg <= cfg_wdata;
                REG_MAX_OUT:  max_out_reg  <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] cnt_reg, scan_idx_reg, chk_idx_reg, surv_cnt_reg, em_idx_reg;
    logic [MAX_BOXES-1:0] picked_reg;
    logic             rdv_reg, found_reg;
    logic [IDX_W-1:0] rd_idx_reg, best_idx_reg;
    box_t             cand_reg;
    logic             keep;
    box_t             box_rd, surv_rd;
    logic [IDX_W-1:0] surv_raddr;

    assign keep = (in_box.score > conf_thr_reg) && (32'(cnt_reg) < MAX_BOXES);

    nms_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
        .aclk  (aclk),
        .we    (cmd.load_en && keep),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (in_box),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (box_rd)
    );

    assign surv_raddr = cmd.em_issue ? em_idx_reg[IDX_W-1:0] : chk_idx_reg[IDX_W-1:0];

    nms_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_surv_ram (
        .aclk  (aclk),
        .we    (cmd.surv_push),
        .waddr (surv_cnt_reg[IDX_W-1:0]),
        .wdata (cand_reg),
        .raddr (surv_raddr),
        .rdata (surv_rd)
    );

    // overlap pipeline
    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, hit_reg;
    logic [14:0]        ox_reg, oy_reg;
    logic [29:0]        qa2_reg, qa3_reg, inter3_reg, inter4_reg, carea_reg;
    logic [30:0]        uni4_reg;
    logic [46:0]        rhs5_reg;
    logic [45:0]        lhs5_reg;
    logic signed [16:0] cl, cr, ql, qr, ct, cb, qt, qb, lo_x, hi_x, lo_y, hi_y;
    logic [14:0]        ox_next, oy_next;

    always_comb begin
        cl = 17'(cand_reg.left);
        ct = 17'(cand_reg.top);
        ql = 17'(surv_rd.left);
        qt = 17'(surv_rd.top);
        cr = cl + $signed({2'b00, cand_reg.width});
        cb = ct + $signed({2'b00, cand_reg.height});
        qr = ql + $signed({2'b00, surv_rd.width});
        qb = qt + $signed({2'b00, surv_rd.height});
        lo_x = (cl > ql) ? cl : ql;
        hi_x = (cr < qr) ? cr : qr;
        lo_y = (ct > qt) ? ct : qt;
        hi_y = (cb < qb) ? cb : qb;
        ox_next = (hi_x > lo_x) ? 15'(hi_x - lo_x) : '0;
        oy_next = (hi_y > lo_y) ? 15'(hi_y - lo_y) : '0;
    end

    always_ff @(posedge aclk) begin
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        qa2_reg    <= 30'(surv_rd.width) * 30'(surv_rd.height);
        inter3_reg <= 30'(ox_reg) * 30'(oy_reg);
        qa3_reg    <= qa2_reg;
        uni4_reg   <= 31'(carea_reg) + 31'(qa3_reg) - 31'(inter3_reg);
        inter4_reg <= inter3_reg;
        rhs5_reg   <= 47'(iou_thr_reg) * 47'(uni4_reg);
        lhs5_reg   <= {inter4_reg, 16'h0000};
        carea_reg  <= 30'(cand_reg.width) * 30'(cand_reg.height);
    end

    logic [CNT_W-1:0] lim, total;

    always_comb begin
        lim   = (32'(max_out_reg) > OUT_CAP) ? CNT_W'(OUT_CAP) : CNT_W'(max_out_reg);
        total = (surv_cnt_reg < lim) ? surv_cnt_reg : lim;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            scan_idx_reg <= '0;
            chk_idx_reg  <= '0;
            surv_cnt_reg <= '0;
            em_idx_reg   <= '0;
            picked_reg   <= '0;
            rdv_reg      <= 1'b0;
            found_reg    <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            hit_reg      <= 1'b0;
            out_valid    <= 1'b0;
        end else begin
            v1_reg  <= cmd.chk_issue;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            rdv_reg <= cmd.scan_issue;
            if (cmd.load_en && keep) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.scan_clr) begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            if (cmd.scan_issue) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            // earliest arrival wins a tie, since the scan runs in arrival order
            if (rdv_reg && !picked_reg[rd_idx_reg] &&
                (!found_reg || box_rd.score > cand_reg.score)) begin
                found_reg <= 1'b1;
            end
            if (cmd.pick) begin
                picked_reg[best_idx_reg] <= 1'b1;
                chk_idx_reg              <= '0;
                hit_reg                  <= 1'b0;
            end
            if (cmd.chk_issue) begin
                chk_idx_reg <= chk_idx_reg + 1'b1;
            end
            if (v5_reg && (47'(lhs5_reg) > rhs5_reg)) begin
                hit_reg <= 1'b1;
            end
            if (cmd.surv_push) begin
                surv_cnt_reg <= surv_cnt_reg + 1'b1;
            end
            if (cmd.em_start) begin
                em_idx_reg <= '0;
            end
            if (cmd.em_load) begin
                em_idx_reg <= em_idx_reg + 1'b1;
            end
            if (out_valid && out_ready) begin
                out_valid <= 1'b0;
            end
            if (cmd.em_load || cmd.em_empty) begin
                out_valid <= 1'b1;
            end
            if (cmd.set_clr) begin
                cnt_reg      <= '0;
                surv_cnt_reg <= '0;
                picked_reg   <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_issue) begin
            rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (rdv_reg && !picked_reg[rd_idx_reg] &&
            (!found_reg || box_rd.score > cand_reg.score)) begin
            best_idx_reg <= rd_idx_reg;
            cand_reg     <= box_rd;
        end
        if (cmd.em_load) begin
            out_box     <= surv_rd;
            out_run_end <= (CNT_W'(em_idx_reg + 1'b1) == total);
            out_none    <= 1'b0;
        end else if (cmd.em_empty) begin
            out_box     <= '0;
            out_run_end <= 1'b1;
            out_none    <= 1'b1;
        end
    end

    always_comb begin
        sts.scan_done = (scan_idx_reg == cnt_reg);
        sts.scan_busy = rdv_reg;
        sts.found     = found_reg;
        sts.chk_done  = (chk_idx_reg == surv_cnt_reg);
        sts.pipe_busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
        sts.hit       = hit_reg;
        sts.em_none   = (total == '0);
        sts.em_done   = (em_idx_reg == total);
        sts.out_full  = out_valid;
    end

    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= MAX_BOXES)
        else $error("stored count beyond capacity");
    a_surv_le_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        surv_cnt_reg <= cnt_reg)
        else $error("more survivors than stored boxes");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.em_load || cmd.em_empty) |-> !out_valid)
        else $error("output word overwritten");
    a_pick_found: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pick |-> found_reg)
        else $error("pick without a candidate");
endmodule
`default_nettype wire

@@ src/box_non_maximum_suppression.sv @@
// top level of the greedy box suppression block
// usage:
//  - input channel s_*: one candidate box per word, s_set_end on the last word of a set;
//    a word is taken when s_valid and s_ready are both high
//  - candidates with score at or below conf_threshold are dropped, as are those past
//    the 64-entry store
//  - loading takes one cycle per word; s_ready is low from the set-end word until all
//    results of the set have been handed to the output register
//  - after set end: for each ranked pick, a scan over the n stored boxes finds the best
//    remaining score, then the pick is checked against the s survivors so far in a
//    five-stage overlap pipeline
//  - output channel m_*: one survivor per word, highest score first, at most max_out;
//    m_run_end marks the last word, a set without survivors gives a single word with
//    m_none_kept high
//  - a stalled receiver holds the output register; the sequencer waits for it
//  - the last word may still wait in the output register while the next set loads
//  - cfg_*: plain write port, index 0 iou threshold, 1 confidence threshold, 2 max_out;
//    write only when idle
//  - reset (aresetn low, synchronous) empties the store and restores the register
//    defaults; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
module box_non_maximum_suppression (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [nms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [nms_pkg::CFG_DAT_W-1:0]     cfg_wdata,
    // candidate words
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [15:0]                s_box_left,
    input  wire logic signed [15:0]                s_box_top,
    input  wire logic [14:0]                       s_box_width,
    input  wire logic [14:0]                       s_box_height,
    input  wire logic [15:0]                       s_score,
    input  wire logic [7:0]                        s_class_id,
    input  wire logic                              s_set_end,
    // result words
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [15:0]                     m_kept_left,
    output logic signed [15:0]                     m_kept_top,
    output logic [14:0]                            m_kept_width,
    output logic [14:0]                            m_kept_height,
    output logic [15:0]                            m_kept_score,
    output logic [7:0]                             m_kept_class,
    output logic                                   m_run_end,
    output logic                                   m_none_kept
);
    import nms_pkg::*;

    cmd_t cmd;
    sts_t sts;
    box_t in_box, out_box;

    // pack the incoming word into the store layout
    always_comb begin
        in_box.left     = s_box_left;
        in_box.top      = s_box_top;
        in_box.width    = s_box_width;
        in_box.height   = s_box_height;
        in_box.score    = s_score;
        in_box.class_id = s_class_id;
    end

    // sequencer: decides phases, issues commands
    nms_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_set_end (s_set_end),
        .s_ready   (s_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // stores, ranking scan, overlap arithmetic, output register
    nms_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_box      (in_box),
        .out_box     (out_box),
        .out_run_end (m_run_end),
        .out_none    (m_none_kept),
        .out_valid   (m_valid),
        .out_ready   (m_ready)
    );

    // unpack the result word
    assign m_kept_left   = out_box.left;
    assign m_kept_top    = out_box.top;
    assign m_kept_width  = out_box.width;
    assign m_kept_height = out_box.height;
    assign m_kept_score  = out_box.score;
    assign m_kept_class  = out_box.class_id;
endmodule
`default_nettype wire
